### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PTMB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptmb assertion failed");

// next-cycle implication, checked outside reset
`define PTMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptmb assertion failed");

`endif

### rtl/ptmb_pkg.sv
`default_nettype none

package ptmb_pkg;

  localparam int TABLE_FRAMES_DEF = 256;
  localparam int ENTRIES_LOG2     = 9;
  localparam int PAGE_SHIFT       = 12;

  localparam logic [63:0] ADDR_MASK = 64'hFFFF_FFFF_FFFF_F000;
  localparam logic [63:0] PTE_FLAGS = 64'h3;

  localparam logic [1:0] LAST_UPPER_LEVEL = 2'd2;
  localparam logic [1:0] LEAF_LEVEL       = 2'd3;

  localparam int   CFG_AW        = 3;
  localparam logic REG_POOL_BASE = 1'b0;

  typedef enum logic {
    OP_MAP  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_OUTSIDE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_ALLOC,
    S_SUB,
    S_CMP,
    S_LEAF,
    S_RDQ,
    S_RDD,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [47:0] va;
    logic [51:0] pa;
    logic [7:0]  frame_index;
    logic [8:0]  entry_index;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  tables_created;
    logic [8:0]  frames_in_use;
    logic [63:0] read_data;
  } res_t;

endpackage

`default_nettype wire

### rtl/page_table_map_builder_top.sv
`default_nettype none

// Page table builder for four-level x86-64 tables kept in an internal store of
// TABLE_FRAMES frames of 512 64-bit entries. After reset the store is cleared
// one entry per cycle; in_tready stays low meanwhile, while pool_base writes
// are taken at any time. A map word walks the three upper levels: each reads
// its entry (S_RD, S_EVAL), then either allocates a table (S_ALLOC) or follows
// the existing entry and range checks it (S_SUB, S_CMP); then come one leaf
// write (S_LEAF) and the result state (S_DONE). A walk that stops on a full
// pool or on an entry outside the pool ends early. A read word reads its entry
// (S_RDQ, S_RDD) before S_DONE, or goes straight to S_DONE for a frame beyond
// the pool. The steps are set by the single port of the table store and the
// one shared subtractor that checks entry addresses. The next word is accepted
// while a result waits in the output register.
module page_table_map_builder_top #(
  parameter int TABLE_FRAMES = ptmb_pkg::TABLE_FRAMES_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // in_tdata: va[47:0], pa[99:48], frame_index[107:100],
  //   entry_index[116:108], zero pad[119:117]
  input  wire  [119:0]               in_tdata,
  // in_tuser: opcode[0]
  input  wire  [0:0]                 in_tuser,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  // out_tdata: status[1:0], tables_created[3:2], frames_in_use[12:4],
  //   read_data[76:13], zero pad[79:77]
  output logic [79:0]                out_tdata,
  output logic                       out_tvalid,
  input  wire                        out_tready,
  input  wire                        cfg_psel,
  input  wire                        cfg_penable,
  input  wire                        cfg_pwrite,
  input  wire  [ptmb_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire  [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic [31:0]    pool_base_r, pool_base_nxt;
  logic [79:0]    out_tdata_r, out_tdata_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;
  ptmb_pkg::req_t req;
  ptmb_pkg::res_t res;
  logic           res_valid;
  logic           res_ready;
  logic           reg_sel;

  assign reg_sel    = (cfg_paddr[2] == ptmb_pkg::REG_POOL_BASE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? pool_base_r : 32'b0;

  always_comb begin
    pool_base_nxt = pool_base_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      pool_base_nxt = cfg_pwdata;
    end
  end

  assign req.op          = ptmb_pkg::op_t'(in_tuser[0]);
  assign req.va          = in_tdata[47:0];
  assign req.pa          = in_tdata[99:48];
  assign req.frame_index = in_tdata[107:100];
  assign req.entry_index = in_tdata[116:108];

  ptmb_walk #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .pool_base (pool_base_r),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output word register, refilled as soon as the old word is taken
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {3'b0, res.read_data, res.frames_in_use,
                        res.tables_created, res.status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      pool_base_r  <= pool_base_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

### rtl/ptmb_walk.sv
`default_nettype none

`include "assert_macros.svh"

module ptmb_walk #(
  parameter int TABLE_FRAMES = ptmb_pkg::TABLE_FRAMES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire [31:0]          pool_base,
  input  wire                 req_valid,
  output logic                req_ready,
  input  ptmb_pkg::req_t      req,
  output logic                res_valid,
  input  wire                 res_ready,
  output ptmb_pkg::res_t      res
);

  localparam int FW    = $clog2(TABLE_FRAMES);
  localparam int AW    = FW + ptmb_pkg::ENTRIES_LOG2;
  localparam int DEPTH = TABLE_FRAMES * (2 ** ptmb_pkg::ENTRIES_LOG2);
  localparam int NW    = $clog2(TABLE_FRAMES + 1);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_r;

  ptmb_pkg::state_t  state_r, state_nxt;
  ptmb_pkg::op_t     op_r, op_nxt;
  ptmb_pkg::status_t status_r, status_nxt;
  logic [47:0]       va_r, va_nxt;
  logic [51:0]       pa_r, pa_nxt;
  logic [8:0]        entry_r, entry_nxt;
  logic [FW-1:0]     frame_r, frame_nxt;
  logic [1:0]        level_r, level_nxt;
  logic [NW-1:0]     nff_r, nff_nxt;
  logic [1:0]        created_r, created_nxt;
  logic [63:0]       data_r, data_nxt;
  logic [64:0]       diff_r, diff_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [63:0]       mem_wdata;
  logic [8:0]        slot_idx;
  logic [31:0]       base_al;
  logic [63:0]       alloc_entry;
  logic [63:0]       leaf_entry;
  logic [31:0]       fi_ext;
  logic [NW+8:0]     nff_ext;

  assign base_al     = {pool_base[31:12], 12'b0};
  assign alloc_entry = ({32'b0, base_al} + (64'(nff_r) << ptmb_pkg::PAGE_SHIFT))
                       | ptmb_pkg::PTE_FLAGS;
  assign leaf_entry  = {12'b0, pa_r} | ptmb_pkg::PTE_FLAGS;
  assign fi_ext      = 32'(req.frame_index);
  assign nff_ext     = {9'b0, nff_r};

  always_comb begin
    if (op_r == ptmb_pkg::OP_READ) begin
      slot_idx = entry_r;
    end else begin
      case (level_r)
        2'd0:    slot_idx = va_r[47:39];
        2'd1:    slot_idx = va_r[38:30];
        2'd2:    slot_idx = va_r[29:21];
        default: slot_idx = va_r[20:12];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ptmb_pkg::S_CLEAR;
      clr_r     <= '0;
      nff_r     <= NW'(1);
      created_r <= '0;
      level_r   <= '0;
      op_r      <= ptmb_pkg::OP_MAP;
      status_r  <= ptmb_pkg::ST_DONE;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      nff_r     <= nff_nxt;
      created_r <= created_nxt;
      level_r   <= level_nxt;
      op_r      <= op_nxt;
      status_r  <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r    <= va_nxt;
    pa_r    <= pa_nxt;
    entry_r <= entry_nxt;
    frame_r <= frame_nxt;
    data_r  <= data_nxt;
    diff_r  <= diff_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    nff_nxt     = nff_r;
    created_nxt = created_r;
    level_nxt   = level_r;
    op_nxt      = op_r;
    status_nxt  = status_r;
    va_nxt      = va_r;
    pa_nxt      = pa_r;
    entry_nxt   = entry_r;
    frame_nxt   = frame_r;
    data_nxt    = data_r;
    diff_nxt    = diff_r;
    mem_we      = 1'b0;
    mem_addr    = {frame_r, slot_idx};
    mem_wdata   = alloc_entry;
    req_ready   = 1'b0;
    res_valid   = 1'b0;

    case (state_r)
      ptmb_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ptmb_pkg::S_IDLE;
        end
      end
      ptmb_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_nxt      = req.op;
          va_nxt      = req.va;
          pa_nxt      = req.pa;
          entry_nxt   = req.entry_index;
          status_nxt  = ptmb_pkg::ST_DONE;
          created_nxt = '0;
          level_nxt   = '0;
          data_nxt    = '0;
          if (req.op == ptmb_pkg::OP_READ) begin
            frame_nxt = fi_ext[FW-1:0];
            if (fi_ext < 32'(TABLE_FRAMES)) begin
              state_nxt = ptmb_pkg::S_RDQ;
            end else begin
              state_nxt = ptmb_pkg::S_DONE;
            end
          end else begin
            frame_nxt = '0;
            state_nxt = ptmb_pkg::S_RD;
          end
        end
      end
      ptmb_pkg::S_RD: begin
        state_nxt = ptmb_pkg::S_EVAL;
      end
      ptmb_pkg::S_EVAL: begin
        if (!rd_data_r[0]) begin
          if (nff_r == NW'(TABLE_FRAMES)) begin
            status_nxt = ptmb_pkg::ST_EXHAUSTED;
            state_nxt  = ptmb_pkg::S_DONE;
          end else begin
            state_nxt = ptmb_pkg::S_ALLOC;
          end
        end else begin
          diff_nxt  = {1'b0, rd_data_r & ptmb_pkg::ADDR_MASK} - {33'b0, base_al};
          state_nxt = ptmb_pkg::S_SUB;
        end
      end
      ptmb_pkg::S_ALLOC: begin
        // new table goes at the current slot, then the walk descends into it
        mem_we      = 1'b1;
        mem_wdata   = alloc_entry;
        frame_nxt   = nff_r[FW-1:0];
        nff_nxt     = nff_r + 1'b1;
        created_nxt = created_r + 1'b1;
        if (level_r == ptmb_pkg::LAST_UPPER_LEVEL) begin
          level_nxt = ptmb_pkg::LEAF_LEVEL;
          state_nxt = ptmb_pkg::S_LEAF;
        end else begin
          level_nxt = level_r + 1'b1;
          state_nxt = ptmb_pkg::S_RD;
        end
      end
      ptmb_pkg::S_SUB: begin
        state_nxt = ptmb_pkg::S_CMP;
      end
      ptmb_pkg::S_CMP: begin
        // borrow means below the pool base
        if (diff_r[64] || (diff_r[63:12] >= 52'(TABLE_FRAMES))) begin
          status_nxt = ptmb_pkg::ST_OUTSIDE;
          state_nxt  = ptmb_pkg::S_DONE;
        end else begin
          frame_nxt = diff_r[12+FW-1:12];
          if (level_r == ptmb_pkg::LAST_UPPER_LEVEL) begin
            level_nxt = ptmb_pkg::LEAF_LEVEL;
            state_nxt = ptmb_pkg::S_LEAF;
          end else begin
            level_nxt = level_r + 1'b1;
            state_nxt = ptmb_pkg::S_RD;
          end
        end
      end
      ptmb_pkg::S_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = leaf_entry;
        data_nxt  = leaf_entry;
        state_nxt = ptmb_pkg::S_DONE;
      end
      ptmb_pkg::S_RDQ: begin
        state_nxt = ptmb_pkg::S_RDD;
      end
      ptmb_pkg::S_RDD: begin
        data_nxt  = rd_data_r;
        state_nxt = ptmb_pkg::S_DONE;
      end
      ptmb_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ptmb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ptmb_pkg::S_IDLE;
      end
    endcase
  end

  assign res.status         = status_r;
  assign res.tables_created = created_r;
  assign res.frames_in_use  = nff_ext[8:0];
  assign res.read_data      = data_r;

  `PTMB_ASSERT_IMPL(a_nff_range, clk, rst_n, 1'b1,
    (nff_r != '0) && (nff_r <= NW'(TABLE_FRAMES)))
  `PTMB_ASSERT_NEXT(a_alloc_counts, clk, rst_n, state_r == ptmb_pkg::S_ALLOC,
    (nff_r == NW'($past(nff_r) + 1'b1)) && (created_r == 2'($past(created_r) + 1'b1)))
  `PTMB_ASSERT_IMPL(a_exhaust_full, clk, rst_n,
    (state_r == ptmb_pkg::S_DONE) && (status_r == ptmb_pkg::ST_EXHAUSTED),
    (nff_r == NW'(TABLE_FRAMES)) && (data_r == '0))

endmodule

`default_nettype wire

### test/tb_page_table_map_builder_top.sv
`timescale 1ns / 1ps

module tb_page_table_map_builder_top;
  import ptmb_pkg::*;

  localparam int FRAMES = TABLE_FRAMES_DEF;
  localparam int SLOTS = FRAMES * 512;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [119:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  page_table_map_builder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  bit [63:0] tbl_mirror [SLOTS];
  int unsigned frames_used = 1;
  logic [31:0] pool_base_q = '0;
  req_t map_req_q[$];
  res_t resp_expect_q[$];
  int unsigned slot_hist[$];
  logic [47:0] va_hist[$];
  req_t drv_req;
  int idle_mode = 0;
  int mismatches = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;
  int cycle_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_slot(input int unsigned slot);
    slot_hist.push_back(slot);
    if (slot_hist.size() > 256) void'(slot_hist.pop_front());
  endfunction

  // walk the mirrored tables the way the block does and queue the result word
  task automatic predict_request(input req_t rq);
    res_t r;
    bit [8:0] idx [4];
    int unsigned frame;
    int unsigned slot;
    int created;
    bit [63:0] ent;
    bit [63:0] addr;
    bit [63:0] base;
    bit [63:0] off;
    r.status = ST_DONE;
    r.read_data = '0;
    created = 0;
    frame = 0;
    if (rq.op == OP_READ) begin
      if (rq.frame_index < FRAMES)
        r.read_data = tbl_mirror[rq.frame_index * 512 + rq.entry_index];
    end else begin
      idx[0] = rq.va[47:39];
      idx[1] = rq.va[38:30];
      idx[2] = rq.va[29:21];
      idx[3] = rq.va[20:12];
      base = {32'd0, pool_base_q & 32'hFFFF_F000};
      for (int lvl = 0; lvl < 3; lvl++) begin
        slot = frame * 512 + idx[lvl];
        ent = tbl_mirror[slot];
        if (!ent[0]) begin
          if (frames_used >= FRAMES) begin
            r.status = ST_EXHAUSTED;
            break;
          end
          ent = (base + (64'(frames_used) << PAGE_SHIFT)) | PTE_FLAGS;
          tbl_mirror[slot] = ent;
          note_slot(slot);
          frames_used++;
          created++;
        end
        addr = ent & ADDR_MASK;
        off = addr - base;
        if (addr < base || (off >> PAGE_SHIFT) >= FRAMES) begin
          r.status = ST_OUTSIDE;
          break;
        end
        frame = int'(off >> PAGE_SHIFT);
      end
      if (r.status == ST_DONE) begin
        r.read_data = {12'd0, rq.pa} | PTE_FLAGS;
        slot = frame * 512 + idx[3];
        tbl_mirror[slot] = r.read_data;
        note_slot(slot);
      end
    end
    r.tables_created = 2'(created);
    r.frames_in_use = 9'(frames_used);
    resp_expect_q.push_back(r);
  endtask

  function automatic req_t req_of(input op_t op, input logic [47:0] va,
                                  input logic [51:0] pa, input logic [7:0] fi,
                                  input logic [8:0] ei);
    req_t rq;
    rq.op = op;
    rq.va = va;
    rq.pa = pa;
    rq.frame_index = fi;
    rq.entry_index = ei;
    return rq;
  endfunction

  // maps reuse earlier walks in all but fresh_pct percent of cases, so that existing tables get followed
  function automatic req_t make_random(input int fresh_pct);
    req_t rq;
    logic [47:0] h;
    int pick;
    int unsigned k;
    rq.va = {16'($urandom), 32'($urandom)};
    rq.pa = {20'($urandom), 32'($urandom)};
    rq.frame_index = 8'($urandom);
    rq.entry_index = 9'($urandom);
    if ($urandom_range(0, 99) < 45) begin
      rq.op = OP_READ;
      if (slot_hist.size() > 0 && $urandom_range(0, 1) == 1) begin
        k = slot_hist[$urandom_range(0, slot_hist.size() - 1)];
        rq.frame_index = 8'(k / 512);
        rq.entry_index = 9'(k % 512);
      end
    end else begin
      rq.op = OP_MAP;
      pick = $urandom_range(0, 99);
      if (va_hist.size() > 0 && pick >= fresh_pct) begin
        h = va_hist[$urandom_range(0, va_hist.size() - 1)];
        if (pick < fresh_pct + 20)
          rq.va[47:30] = h[47:30];
        else
          rq.va[47:21] = h[47:21];
      end
      va_hist.push_back(rq.va);
      if (va_hist.size() > 64) void'(va_hist.pop_front());
    end
    return rq;
  endfunction

  task automatic push_item(input req_t rq);
    @(negedge clk);
    while (map_req_q.size() >= 4) @(negedge clk);
    map_req_q.push_back(rq);
  endtask

  task automatic run_random(input int count, input int fresh_pct);
    for (int n = 0; n < count; n++) push_item(make_random(fresh_pct));
  endtask

  task automatic wait_drained();
    while (map_req_q.size() != 0 || in_tvalid || resp_expect_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_pool_base(input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'({REG_POOL_BASE, 2'b00});
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    pool_base_q = val;
  endtask

  // after a base change the old entries may fall outside the pool
  task automatic probe_new_base();
    push_item(req_of(OP_MAP, 48'h0, 52'h0_0000_0ABC_D000, 8'h00, 9'h000));
    push_item(req_of(OP_MAP, '1, 52'h8_0000_0000_0000, 8'h00, 9'h000));
    push_item(req_of(OP_READ, 48'h0, 52'h0, 8'h00, 9'h000));
  endtask

  always @(posedge clk) begin : drive_words
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_request(drv_req);
      if (!in_tvalid || in_tready) begin
        if (map_req_q.size() > 0 &&
            $urandom_range(0, 99) >= ((idle_mode == 0) ? 11 : (idle_mode == 1) ? 68 : 0))
        begin
          drv_req = map_req_q.pop_front();
          in_tdata <= {3'b000, drv_req.entry_index, drv_req.frame_index,
                       drv_req.pa, drv_req.va};
          in_tuser <= drv_req.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : hold_off
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && results_seen >= 150) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : check_words
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tdata[1:0]);
        got.tables_created = out_tdata[3:2];
        got.frames_in_use = out_tdata[12:4];
        got.read_data = out_tdata[76:13];
        results_seen <= results_seen + 1;
        if (resp_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
        end else begin
          want = resp_expect_q.pop_front();
          if (got.status !== want.status || got.tables_created !== want.tables_created ||
              got.frames_in_use !== want.frames_in_use || got.read_data !== want.read_data)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp st %0d tbl %0d frm %0d data %h,",
                        " got st %0d tbl %0d frm %0d data %h"},
                       want.status, want.tables_created, want.frames_in_use, want.read_data,
                       got.status, got.tables_created, got.frames_in_use, got.read_data);
          end
        end
      end
      out_tready <= (hold_left == 0) &&
                    ($urandom_range(0, 99) >= ((idle_mode == 0) ? 68 : (idle_mode == 1) ? 11 : 0));
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_pool_base(32'h0000_0000);

    push_item(req_of(OP_READ, 48'h0, 52'h0, 8'h00, 9'h000));
    push_item(req_of(OP_READ, '1, '1, 8'hFF, 9'h1FF));
    push_item(req_of(OP_MAP, 48'h0, 52'h0, 8'h00, 9'h000));
    push_item(req_of(OP_MAP, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 8'hFF, 9'h1FF));
    push_item(req_of(OP_MAP, 48'h0000_0000_1000, 52'h0_0000_0012_3000, 8'h00, 9'h000));
    push_item(req_of(OP_MAP, 48'h0080_0000_0000, 52'h0_0000_0045_6000, 8'h00, 9'h000));
    push_item(req_of(OP_MAP, 48'h0000_4000_0000, 52'h0_0000_0078_9000, 8'h00, 9'h000));
    push_item(req_of(OP_MAP, 48'h0000_0020_0000, 52'hA_BCDE_F012_3000, 8'h00, 9'h000));
    push_item(req_of(OP_MAP, 48'h0, 52'h5_5555_5555_5557, 8'h00, 9'h000));
    push_item(req_of(OP_READ, 48'h0, 52'h0, 8'h00, 9'h000));
    push_item(req_of(OP_READ, 48'h0, 52'h0, 8'h00, 9'h1FF));
    push_item(req_of(OP_READ, 48'h0, 52'h0, 8'h01, 9'h000));
    push_item(req_of(OP_READ, 48'h0, 52'h0, 8'h03, 9'h000));
    push_item(req_of(OP_READ, 48'h0, 52'h0, 8'h03, 9'h001));
    push_item(req_of(OP_READ, 48'h0, 52'h0, 8'h01, 9'h1FF));
    run_random(250, 10);
    wait_drained();

    write_pool_base(32'h0000_1ABC);
    probe_new_base();
    run_random(150, 10);
    wait_drained();

    idle_mode = 1;
    write_pool_base(32'hFFFF_FFFF);
    probe_new_base();
    run_random(200, 10);
    wait_drained();

    write_pool_base(32'h0000_0000);
    probe_new_base();
    run_random(150, 10);
    wait_drained();

    // mostly fresh walks here so the pool runs dry
    idle_mode = 2;
    run_random(150, 60);
    wait_drained();

    repeat (40) @(negedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
